FILE: hdl/kwi_pkg.sv
`default_nettype none

package kwi_pkg;

   // Item commands.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   // Configuration register indexes.
   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_LOOP_DURATION = 1'b0;
   localparam csr_index_type CSR_KEY_COUNT     = 1'b1;

   localparam logic [31:0] LOOP_DURATION_RESET = 32'd65536;
   localparam logic [4:0]  KEY_COUNT_RESET     = 5'd1;

   // Shift-subtract divider step counts: full modulo and a Q0.16 fraction.
   localparam logic [5:0] MOD_STEPS  = 6'd32;
   localparam logic [5:0] FRAC_STEPS = 6'd16;

   typedef struct packed {
      logic               command;
      logic [3:0]         key_slot;
      logic [31:0]        key_time;
      logic signed [15:0] key_first_weight;
      logic signed [15:0] key_second_weight;
      logic [31:0]        query_time;
   } req_type;

   typedef struct packed {
      logic signed [15:0] first_weight;
      logic signed [15:0] second_weight;
      logic [3:0]         segment;
   } rsp_type;

   typedef struct packed {
      logic [31:0]        key_time;
      logic signed [15:0] first_weight;
      logic signed [15:0] second_weight;
   } key_entry_type;

   typedef struct packed {
      logic capture;
      logic div_step;
      logic wrap;
      logic first;
      logic pick_first;
      logic pick_pair;
      logic pick_last;
      logic advance;
      logic mult;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_is_eval;
      logic single;
      logic before_key;
      logic seg_pos;
      logic is_last;
      logic div_last;
      logic rsp_free;
   } ctrl_status_type;

endpackage

`default_nettype wire

FILE: hdl/keyframe_weight_interpolator.sv
`default_nettype none

// Channel   Direction  Handshake             Word
// req_      in         req_valid/req_stall   write keyframe or evaluate at time
// rsp_      out        rsp_valid/rsp_stall   two blended weights and segment
// csr_      in         csr_write_enable      loop duration, key count
//
// A keyframe write is taken without a stall. After an evaluation is taken the
// input stalls while the block takes the modulo on the shared shift-subtract
// divider, wraps the time, tests the first key, scans up to n - 1 further keys
// with n the key count (one table read a cycle), takes the blend fraction on
// the same divider, multiplies and loads the result. With one key, or a time
// ahead of the first key, the scan and the fraction are skipped.
// Reset is synchronous; the key table itself is not cleared.
// A finished word waits in the output register while the next item is taken;
// the input stays stalled as long as a new result finds that register held.

module keyframe_weight_interpolator #(
   parameter int MAX_KEYS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire kwi_pkg::req_type       req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output kwi_pkg::rsp_type            rsp_payload,
   input  wire logic                   csr_write_enable,
   input  wire kwi_pkg::csr_index_type csr_index,
   input  wire logic [31:0]            csr_write_data
);

   import kwi_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   kwi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   kwi_dp #(
      .MAX_KEYS (MAX_KEYS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload)
   );

endmodule

`default_nettype wire

FILE: hdl/kwi_ram.sv
`default_nettype none

module kwi_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_addr,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_addr,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

FILE: hdl/kwi_ctrl.sv
`default_nettype none

module kwi_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire kwi_pkg::ctrl_status_type status,
   output kwi_pkg::ctrl_cmd_type         cmd
);

   import kwi_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_MOD   = 8'b0000_0010,
      S_WRAP  = 8'b0000_0100,
      S_FIRST = 8'b0000_1000,
      S_SCAN  = 8'b0001_0000,
      S_FRAC  = 8'b0010_0000,
      S_BLEND = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid && status.req_is_eval) begin
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_WRAP;
            end
         end
         S_WRAP: begin
            cmd.wrap = 1'b1;
            state_in = S_FIRST;
         end
         S_FIRST: begin
            // One key, or a time ahead of the first key, returns key 0.
            if (status.single || status.before_key) begin
               cmd.pick_first = 1'b1;
               state_in       = S_BLEND;
            end else begin
               cmd.first = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (status.before_key) begin
               cmd.pick_pair = 1'b1;
               // A zero-length segment keeps a zero factor.
               state_in = status.seg_pos ? S_FRAC : S_BLEND;
            end else if (status.is_last) begin
               cmd.pick_last = 1'b1;
               state_in      = S_BLEND;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         S_FRAC: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_BLEND;
            end
         end
         S_BLEND: begin
            cmd.mult = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

`default_nettype wire

FILE: hdl/kwi_dp.sv
`default_nettype none

module kwi_dp #(
   parameter int MAX_KEYS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire kwi_pkg::ctrl_cmd_type    cmd,
   output kwi_pkg::ctrl_status_type      status,
   input  wire kwi_pkg::req_type         req_payload,
   input  wire logic                     csr_write_enable,
   input  wire kwi_pkg::csr_index_type   csr_index,
   input  wire logic [31:0]              csr_write_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output kwi_pkg::rsp_type              rsp_payload
);

   import kwi_pkg::*;

   localparam int AW = $clog2(MAX_KEYS);
   localparam int NW = $clog2(MAX_KEYS + 1);
   localparam int EW = $bits(key_entry_type);

   // Configuration.
   logic [31:0] loop_ff, loop_in;
   logic [4:0]  kcount_ff, kcount_in;

   // Evaluation working registers.
   logic [NW-1:0]  n_ff, n_in, n_eff;
   logic [31:0]    query_ff, query_in;
   logic [31:0]    wt_ff, wt_in;
   logic [AW-1:0]  idx_ff, idx_in;
   key_entry_type  prev_ff, prev_in;
   key_entry_type  a_ff, a_in;
   key_entry_type  b_ff, b_in;
   logic [3:0]     seg_ff, seg_in;

   // Shared shift-subtract divider.
   logic [31:0] rem_ff, rem_in;
   logic [31:0] num_ff, num_in;
   logic [31:0] den_ff, den_in;
   logic [15:0] q_ff, q_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] div_shift, div_diff;
   logic        div_ge;
   logic [31:0] div_rem;

   // Blend.
   logic signed [33:0] p1_ff, p1_in, p2_ff, p2_in;
   logic signed [16:0] d1, d2, fs;
   logic signed [34:0] sum1, sum2;

   // Result register.
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    rsp_free;

   // Key table.
   logic          ram_we;
   key_entry_type ram_wdata;
   logic [EW-1:0] ram_rdata;
   key_entry_type rd_entry;
   logic          slot_ok;

   kwi_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_KEYS)
   ) u_key_ram (
      .clock        (clock),
      .write_enable (ram_we),
      .write_addr   (AW'(req_payload.key_slot)),
      .write_data   (ram_wdata),
      .read_addr    (idx_in),
      .read_data    (ram_rdata)
   );

   assign rd_entry  = ram_rdata;
   assign slot_ok   = (32'(req_payload.key_slot) < MAX_KEYS);
   assign ram_we    = cmd.capture && (req_payload.command == CMD_WRITE) && slot_ok;
   assign ram_wdata = '{key_time:      req_payload.key_time,
                        first_weight:  req_payload.key_first_weight,
                        second_weight: req_payload.key_second_weight};

   always_comb begin
      loop_in   = loop_ff;
      kcount_in = kcount_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_LOOP_DURATION: loop_in   = csr_write_data;
            CSR_KEY_COUNT:     kcount_in = csr_write_data[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (kcount_ff == 5'd0) begin
         n_eff = NW'(1);
      end else if (32'(kcount_ff) > MAX_KEYS) begin
         n_eff = NW'(MAX_KEYS);
      end else begin
         n_eff = NW'(kcount_ff);
      end
   end

   // Restoring division: one quotient bit a cycle, the dividend shifted in MSB first.
   assign div_shift = {rem_ff, num_ff[31]};
   assign div_diff  = div_shift - {1'b0, den_ff};
   assign div_ge    = (div_shift >= {1'b0, den_ff});
   assign div_rem   = div_ge ? div_diff[31:0] : div_shift[31:0];

   // Weight = w0 + (w1 - w0) * f / 65536, rounded half up.
   assign fs   = signed'({1'b0, q_ff});
   assign d1   = 17'(b_ff.first_weight) - 17'(a_ff.first_weight);
   assign d2   = 17'(b_ff.second_weight) - 17'(a_ff.second_weight);
   assign sum1 = 35'(signed'({a_ff.first_weight, 16'h0000})) + 35'(p1_ff) + 35'sd32768;
   assign sum2 = 35'(signed'({a_ff.second_weight, 16'h0000})) + 35'(p2_ff) + 35'sd32768;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      n_in     = n_ff;
      query_in = query_ff;
      wt_in    = wt_ff;
      idx_in   = idx_ff;
      prev_in  = prev_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      seg_in   = seg_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;

      if (cmd.capture) begin
         n_in     = n_eff;
         query_in = req_payload.query_time;
         idx_in   = '0;
         rem_in   = '0;
         num_in   = req_payload.query_time;
         den_in   = loop_ff;
         q_in     = '0;
         cnt_in   = MOD_STEPS;
      end
      if (cmd.div_step) begin
         rem_in = div_rem;
         num_in = {num_ff[30:0], 1'b0};
         q_in   = {q_ff[14:0], div_ge};
         cnt_in = cnt_ff - 6'd1;
      end
      if (cmd.wrap) begin
         // A zero loop length leaves the time unwrapped.
         wt_in = (loop_ff == 32'd0) ? query_ff : rem_ff;
      end
      if (cmd.first) begin
         prev_in = rd_entry;
         idx_in  = AW'(1);
      end
      if (cmd.pick_first) begin
         a_in   = rd_entry;
         b_in   = rd_entry;
         seg_in = 4'd0;
         q_in   = '0;
      end
      if (cmd.pick_pair) begin
         a_in   = prev_ff;
         b_in   = rd_entry;
         seg_in = 4'(idx_ff - AW'(1));
         // The offset is below the segment length, so the quotient fits the Q0.16 fraction.
         rem_in = wt_ff - prev_ff.key_time;
         num_in = '0;
         den_in = rd_entry.key_time - prev_ff.key_time;
         q_in   = '0;
         cnt_in = FRAC_STEPS;
      end
      if (cmd.pick_last) begin
         a_in   = rd_entry;
         b_in   = rd_entry;
         seg_in = 4'(n_ff - NW'(2));
         q_in   = '0;
      end
      if (cmd.advance) begin
         prev_in = rd_entry;
         idx_in  = idx_ff + AW'(1);
      end
      if (cmd.mult) begin
         p1_in = d1 * fs;
         p2_in = d2 * fs;
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_in.first_weight  = sum1[31:16];
         rsp_in.second_weight = sum2[31:16];
         rsp_in.segment       = seg_ff;
         rsp_valid_in         = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_ff      <= LOOP_DURATION_RESET;
         kcount_ff    <= KEY_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
      end else begin
         loop_ff      <= loop_in;
         kcount_ff    <= kcount_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      query_ff <= query_in;
      wt_ff    <= wt_in;
      prev_ff  <= prev_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      seg_ff   <= seg_in;
      rem_ff   <= rem_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      q_ff     <= q_in;
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      rsp_ff   <= rsp_in;
   end

   assign status.req_is_eval = (req_payload.command == CMD_EVAL);
   assign status.single      = (n_ff == NW'(1));
   assign status.before_key  = (wt_ff < rd_entry.key_time);
   assign status.seg_pos     = (rd_entry.key_time > prev_ff.key_time);
   assign status.is_last     = (NW'(idx_ff) == n_ff - NW'(1));
   assign status.div_last    = (cnt_ff == 6'd1);
   assign status.rsp_free    = rsp_free;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> cnt_ff != 6'd0)
      else $error("divider stepped with no steps left");

   a_pair_index: assert property (@(posedge clock) disable iff (reset)
      cmd.pick_pair |-> idx_ff != '0)
      else $error("segment picked without a start key");

   a_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> rsp_free)
      else $error("result register loaded while a word is still held");

   a_mod_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.wrap && loop_ff != 32'd0) |-> rem_ff < loop_ff)
      else $error("wrapped time not below the loop duration");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import kwi_pkg::*;

   localparam int KEY_SLOTS     = 16;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 100;
   localparam int ROUNDS        = 20;
   localparam int EVALS_PER_SET = 28;

   logic          clock            = 1'b0;
   logic          reset            = 1'b1;
   logic          req_valid        = 1'b0;
   logic          req_stall;
   req_type       req_payload      = '0;
   logic          rsp_valid;
   logic          rsp_stall        = 1'b0;
   rsp_type       rsp_payload;
   logic          csr_write_enable = 1'b0;
   csr_index_type csr_index        = CSR_LOOP_DURATION;
   logic [31:0]   csr_write_data   = '0;

   // Shadow of the block's registers and key table, updated as words are accepted.
   logic [31:0]        loop_length = LOOP_DURATION_RESET;
   logic [4:0]         key_total   = KEY_COUNT_RESET;
   logic [31:0]        table_time   [KEY_SLOTS];
   logic signed [15:0] table_first  [KEY_SLOTS];
   logic signed [15:0] table_second [KEY_SLOTS];

   // Key times as planned by the stimulus, used to aim queries at the keys.
   logic [31:0] plan_time [KEY_SLOTS];

   req_type pending_words[$];
   rsp_type expected_blends[$];
   logic    word_taken = 1'b0;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int error_count   = 0;
   int write_count   = 0;
   int eval_count    = 0;
   int blend_checks  = 0;
   int setting_count = 0;
   int cycle_count   = 0;

   keyframe_weight_interpolator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Rounded blend of two Q2.14 weights by a Q0.16 fraction; the arithmetic
   // shift gives the floor for negative sums as well.
   function automatic logic signed [15:0] blend_weight(logic signed [15:0] w0,
                                                       logic signed [15:0] w1,
                                                       logic [16:0] frac);
      longint a;
      longint b;
      longint f;
      longint acc;
      a = w0;
      b = w1;
      f = frac;
      acc = a * (65536 - f) + b * f + 32768;
      return 16'(acc >>> 16);
   endfunction

   function automatic rsp_type interpolate_keys(logic [31:0] query);
      int                 n;
      int                 seg;
      int                 hit;
      logic [31:0]        t;
      logic [31:0]        t0;
      logic [31:0]        t1;
      logic [47:0]        quotient;
      logic [16:0]        frac;
      logic signed [15:0] a1, a2, b1, b2;
      rsp_type            r;
      n = key_total;
      if (n == 0) n = 1;
      if (n > KEY_SLOTS) n = KEY_SLOTS;
      t = (loop_length != 0) ? query % loop_length : query;
      seg = 0;
      frac = '0;
      a1 = table_first[0];
      a2 = table_second[0];
      b1 = a1;
      b2 = a2;
      if (n > 1 && t >= table_time[0]) begin
         hit = -1;
         for (int i = 0; i + 1 < n; i++)
            if (hit < 0 && t < table_time[i + 1]) hit = i;
         if (hit >= 0) begin
            seg = hit;
            t0 = table_time[hit];
            t1 = table_time[hit + 1];
            a1 = table_first[hit];
            a2 = table_second[hit];
            b1 = table_first[hit + 1];
            b2 = table_second[hit + 1];
            if (t1 > t0 && t >= t0) begin
               quotient = {t - t0, 16'h0000} / {16'h0000, t1 - t0};
               frac = (quotient > 48'd65535) ? 17'd65535 : quotient[16:0];
            end
         end else begin
            // Past the last key the table clamps to that key.
            seg = n - 2;
            a1 = table_first[n - 1];
            a2 = table_second[n - 1];
            b1 = a1;
            b2 = a2;
         end
      end
      r.first_weight  = blend_weight(a1, b1, frac);
      r.second_weight = blend_weight(a2, b2, frac);
      r.segment       = 4'(seg);
      return r;
   endfunction

   // Result checking and prediction, both at the rising edge.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_blends.size() == 0) begin
               $error("result word with no evaluation outstanding: %p", rsp_payload);
               error_count++;
            end else begin
               want = expected_blends.pop_front();
               blend_checks++;
               if (rsp_payload.first_weight !== want.first_weight) begin
                  $error("first_weight mismatch: expected %0d, got %0d",
                         want.first_weight, rsp_payload.first_weight);
                  error_count++;
               end
               if (rsp_payload.second_weight !== want.second_weight) begin
                  $error("second_weight mismatch: expected %0d, got %0d",
                         want.second_weight, rsp_payload.second_weight);
                  error_count++;
               end
               if (rsp_payload.segment !== want.segment) begin
                  $error("segment mismatch: expected %0d, got %0d",
                         want.segment, rsp_payload.segment);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_payload.command == CMD_WRITE) begin
               table_time[req_payload.key_slot]   = req_payload.key_time;
               table_first[req_payload.key_slot]  = req_payload.key_first_weight;
               table_second[req_payload.key_slot] = req_payload.key_second_weight;
               write_count++;
            end else begin
               expected_blends.push_back(interpolate_keys(req_payload.query_time));
               eval_count++;
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_LOOP_DURATION: loop_length = csr_write_data;
               CSR_KEY_COUNT:     key_total   = csr_write_data[4:0];
               default: ;
            endcase
         end
      end
      word_taken <= !reset && req_valid && !req_stall;
   end

   // Request driver: a new word goes out only once the current one was taken.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || word_taken) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_payload <= pending_words.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run timed out with %0d words queued and %0d results outstanding.",
                  pending_words.size(), expected_blends.size());
         $display("** keyframe_weight_interpolator: FAILED **");
         $finish;
      end
   end

   task automatic queue_key(int slot, logic [31:0] key_t,
                            logic signed [15:0] w1, logic signed [15:0] w2);
      req_type w;
      w.command           = CMD_WRITE;
      w.key_slot          = 4'(slot);
      w.key_time          = key_t;
      w.key_first_weight  = w1;
      w.key_second_weight = w2;
      w.query_time        = $urandom;
      pending_words.push_back(w);
      plan_time[slot] = key_t;
   endtask

   task automatic queue_eval(logic [31:0] query);
      req_type w;
      w.command           = CMD_EVAL;
      w.key_slot          = 4'($urandom);
      w.key_time          = $urandom;
      w.key_first_weight  = 16'($urandom);
      w.key_second_weight = 16'($urandom);
      w.query_time        = query;
      pending_words.push_back(w);
   endtask

   // Configuration is only touched with the block idle.
   task automatic wait_until_drained();
      while (pending_words.size() != 0 || req_valid || expected_blends.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type index, logic [31:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_timeline(logic [31:0] loop, logic [4:0] count);
      write_csr(CSR_LOOP_DURATION, loop);
      write_csr(CSR_KEY_COUNT, {27'd0, count});
      setting_count++;
   endtask

   // Ascending key times spread over one loop, with an occasional repeated
   // time; a scrambled set ignores ordering altogether.
   task automatic build_key_set(int count, logic [31:0] loop, bit scrambled);
      longint unsigned span;
      longint unsigned step;
      longint unsigned t;
      span = (loop == 0) ? 64'h1_0000_0000 : 64'(loop);
      step = span / (count + 1);
      t = {$urandom, $urandom} % (step + 1);
      for (int slot = 0; slot < count; slot++) begin
         if (slot > 0 && $urandom_range(0, 7) != 0)
            t = t + 1 + ({$urandom, $urandom} % (step + 1));
         queue_key(slot, scrambled ? 32'($urandom) : 32'(t), 16'($urandom), 16'($urandom));
      end
   endtask

   function automatic logic [31:0] pick_query(int count, logic [31:0] loop);
      longint unsigned span;
      span = (loop == 0) ? 64'h1_0000_0000 : 64'(loop);
      case ($urandom_range(0, 3))
         0, 1: return 32'({$urandom, $urandom} % span);
         // Just around a key, possibly a few loops later.
         2: return plan_time[$urandom_range(0, count - 1)] + $urandom_range(0, 2) - 1
                   + loop * $urandom_range(0, 2);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [31:0] prev_time;
      logic [31:0] loop_pick;
      logic [4:0]  count_pick;
      int          keys_live;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fill the whole table first so that no evaluation reads an empty entry.
      prev_time = 32'h0000_0100;
      for (int slot = 0; slot < KEY_SLOTS; slot++) begin
         if (slot == 15)
            prev_time = 32'hFFFF_FFFF;
         else if (slot > 0 && slot != 6)
            prev_time = prev_time + $urandom_range(1, 32'h0F00_0000);
         case (slot)
            0:       queue_key(slot, prev_time, 16'sh8000, 16'sh7FFF);
            1:       queue_key(slot, prev_time, 16'sh7FFF, 16'sh8000);
            2:       queue_key(slot, prev_time, 16'sh0000, 16'shFFFF);
            default: queue_key(slot, prev_time, 16'($urandom), 16'($urandom));
         endcase
      end
      // One key after reset: every time gives key 0.
      queue_eval(32'hFFFF_FFFF);
      queue_eval(32'h0000_0000);

      wait_until_drained();
      set_timeline(32'd0, 5'd16);
      queue_eval(32'h0000_0000);
      queue_eval(32'h0000_0100);
      queue_eval(plan_time[6]);
      queue_eval(plan_time[7] - 1);
      queue_eval(32'hFFFF_FFFE);
      queue_eval(32'hFFFF_FFFF);

      // A key count of zero behaves as one key.
      wait_until_drained();
      set_timeline(32'hFFFF_FFFF, 5'd0);
      queue_eval(32'hFFFF_FFFF);

      // A key count beyond the table behaves as a full table.
      wait_until_drained();
      set_timeline(32'd1000, 5'd31);
      queue_eval(32'd99);
      queue_eval($urandom);

      for (int round = 0; round < ROUNDS; round++) begin
         wait_until_drained();
         case ($urandom_range(0, 5))
            0:       loop_pick = 32'd0;
            1:       loop_pick = 32'hFFFF_FFFF;
            2:       loop_pick = $urandom_range(1, 16);
            3, 4:    loop_pick = $urandom_range(32'h0001_0000, 32'h0040_0000);
            default: loop_pick = $urandom;
         endcase
         case ($urandom_range(0, 9))
            0:       count_pick = 5'd0;
            1:       count_pick = 5'($urandom_range(17, 31));
            2:       count_pick = 5'd16;
            3:       count_pick = 5'd1;
            default: count_pick = 5'($urandom_range(2, 16));
         endcase
         keys_live = (count_pick == 0) ? 1 : (count_pick > 16) ? 16 : count_pick;
         set_timeline(loop_pick, count_pick);
         case (round % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 56; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 56; end
            default: begin send_idle_pct = 12; stall_pct = 12; end
         endcase
         build_key_set(keys_live, loop_pick, $urandom_range(0, 5) == 0);
         for (int k = 0; k < EVALS_PER_SET; k++) begin
            // Stray key writes between evaluations shuffle the table now and then.
            if ($urandom_range(0, 7) == 0)
               queue_key($urandom_range(0, 15), $urandom, 16'($urandom), 16'($urandom));
            else
               queue_eval(pick_query(keys_live, loop_pick));
         end
      end

      wait_until_drained();
      $display("Ran %0d keyframe writes and %0d evaluations over %0d timeline settings,",
               write_count, eval_count, setting_count);
      $display("with %0d result words checked and %0d mismatches found.",
               blend_checks, error_count);
      if (error_count == 0)
         $display("** keyframe_weight_interpolator: PASSED **");
      else
         $display("** keyframe_weight_interpolator: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
